@@ src/gvbm_pkg.sv @@
// shared constants and types for the grid vertex to ball mapper
package gvbm_pkg;

    localparam int IDX_W         = 10;
    localparam int FRAC_BITS     = 14;
    localparam int COORD_W       = 16;
    localparam int VN_W          = 30;
    localparam logic [IDX_W-1:0] MAX_DIVISIONS = 10'd1023;

    localparam int STRIDE_W      = IDX_W + 1;
    localparam int STRIDE_SQ_W   = 2 * IDX_W + 1;
    localparam int PART_W        = 2 * IDX_W;

    localparam int MAG_W         = FRAC_BITS + 1;
    localparam int SQ_W          = 2 * MAG_W - 1;
    localparam int SUM_W         = SQ_W + 1;
    localparam int PROD_W        = SQ_W;
    localparam int ROOT_W        = MAG_W + 1;

    localparam int DIV_NUM_W     = SUM_W;
    localparam int DIV_DEN_W     = ROOT_W + 1;
    localparam int DIV_STAGES    = MAG_W;
    localparam int DIV_TRIAL_W   = DIV_DEN_W + DIV_STAGES - 1;

    localparam int SQRT_ITERS    = SUM_W / 2;
    localparam int SQRT_STAGES   = SQRT_ITERS + 1;
    localparam int SQRT_RES_W    = SUM_W + 1;

    localparam int IN_TDATA_W    = ((3 * IDX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((3 * COORD_W + VN_W + 7) / 8) * 8;

    localparam logic signed [COORD_W-1:0] COORD_ONE = 16'sd16384;

    // pipeline stage numbers
    localparam int ST_CLAMP      = 1;
    localparam int ST_PREP       = 2;
    localparam int ST_VN         = 3;
    localparam int ST_SQ         = ST_PREP + DIV_STAGES + 1;
    localparam int ST_SUM        = ST_SQ + 1;
    localparam int ST_ROUND      = ST_SUM + SQRT_STAGES;
    localparam int ST_DIV2IN     = ST_ROUND + 1;
    localparam int ST_LAST       = ST_DIV2IN + DIV_STAGES;

    typedef struct packed {
        logic [VN_W-1:0] vn;
        logic [2:0]      neg;
    } side_t;

endpackage

@@ src/gvbm_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module gvbm_div (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [gvbm_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [gvbm_pkg::DIV_DEN_W-1:0] divisor,
    output logic [gvbm_pkg::MAG_W-1:0]     quotient
);

    logic [gvbm_pkg::DIV_NUM_W-1:0] rem_reg  [gvbm_pkg::DIV_STAGES];
    logic [gvbm_pkg::DIV_DEN_W-1:0] den_reg  [gvbm_pkg::DIV_STAGES];
    logic [gvbm_pkg::MAG_W-1:0]     quot_reg [gvbm_pkg::DIV_STAGES];

    for (genvar j = 0; j < gvbm_pkg::DIV_STAGES; j++) begin : g_stage
        logic [gvbm_pkg::DIV_NUM_W-1:0]   rem_in;
        logic [gvbm_pkg::DIV_DEN_W-1:0]   den_in;
        logic [gvbm_pkg::MAG_W-1:0]       quot_in;
        logic [gvbm_pkg::DIV_TRIAL_W-1:0] trial;
        logic                             fits;
        logic [gvbm_pkg::DIV_NUM_W-1:0]   rem_next;
        logic [gvbm_pkg::MAG_W-1:0]       quot_next;

        if (j == 0) begin : g_first
            assign rem_in  = dividend;
            assign den_in  = divisor;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign quot_in = quot_reg[j-1];
        end

        assign trial = gvbm_pkg::DIV_TRIAL_W'(den_in) << (gvbm_pkg::DIV_STAGES - 1 - j);
        assign fits  = gvbm_pkg::DIV_TRIAL_W'(rem_in) >= trial;
        assign rem_next  = fits ? rem_in - trial[gvbm_pkg::DIV_NUM_W-1:0] : rem_in;
        assign quot_next = quot_in
                         | (gvbm_pkg::MAG_W'(fits) << (gvbm_pkg::DIV_STAGES - 1 - j));

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_in;
                quot_reg[j] <= quot_next;
            end
        end
    end

    assign quotient = quot_reg[gvbm_pkg::DIV_STAGES-1];

endmodule

@@ src/gvbm_sqrt.sv @@
// pipelined integer square root, rounded to nearest, one result bit per stage
module gvbm_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [gvbm_pkg::SUM_W-1:0]  radicand,
    output logic [gvbm_pkg::ROOT_W-1:0] root
);

    logic [gvbm_pkg::SUM_W-1:0]      rem_reg [gvbm_pkg::SQRT_ITERS];
    logic [gvbm_pkg::SQRT_RES_W-1:0] res_reg [gvbm_pkg::SQRT_ITERS];
    logic [gvbm_pkg::ROOT_W-1:0]     root_reg;

    for (genvar t = 0; t < gvbm_pkg::SQRT_ITERS; t++) begin : g_stage
        localparam logic [gvbm_pkg::SQRT_RES_W-1:0] BIT =
            gvbm_pkg::SQRT_RES_W'(1) << (2 * (gvbm_pkg::SQRT_ITERS - 1 - t));
        logic [gvbm_pkg::SUM_W-1:0]      rem_in;
        logic [gvbm_pkg::SQRT_RES_W-1:0] res_in;
        logic [gvbm_pkg::SQRT_RES_W-1:0] trial;
        logic                            fits;

        if (t == 0) begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[t-1];
            assign res_in = res_reg[t-1];
        end

        assign trial = res_in + BIT;
        assign fits  = gvbm_pkg::SQRT_RES_W'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[t] <= fits ? rem_in - trial[gvbm_pkg::SUM_W-1:0] : rem_in;
                res_reg[t] <= fits ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end
    end

    logic [gvbm_pkg::SUM_W-1:0]      rem_fin;
    logic [gvbm_pkg::SQRT_RES_W-1:0] res_fin;
    logic                            round_up;
    logic [gvbm_pkg::ROOT_W-1:0]     root_sum;

    assign rem_fin  = rem_reg[gvbm_pkg::SQRT_ITERS-1];
    assign res_fin  = res_reg[gvbm_pkg::SQRT_ITERS-1];
    assign round_up = gvbm_pkg::SQRT_RES_W'(rem_fin) > res_fin;
    assign root_sum = res_fin[gvbm_pkg::ROOT_W-1:0] + gvbm_pkg::ROOT_W'(round_up);

    // zero root only for the centre point, kept at one
    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= (root_sum == '0) ? gvbm_pkg::ROOT_W'(1) : root_sum;
        end
    end

    assign root = root_reg;

endmodule

@@ src/grid_vertex_to_ball_map.sv @@
// top level: grid point to ball coordinate mapper
//
//  channel   | direction | fields (lowest bit up)
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | index_x, index_y, index_z
//  m_axis    | out       | coord_x, coord_y, coord_z, vertex_number
//  cfg       | in        | grid_divisions
//
//  one transaction per cycle while s_tready is high; a result's path to m_tvalid
//  runs through two 15-stage dividers and a 16-stage square root
//  reset clears all valid bits and sets grid_divisions to 1
//  the pipeline advances while the output skid register is empty; s_tready
//  drops only while both the output and skid registers hold results
module grid_vertex_to_ball_map (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gvbm_pkg::IDX_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gvbm_pkg::IN_TDATA_W-1:0]  s_tdata,   // index_x, index_y, index_z
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gvbm_pkg::OUT_TDATA_W-1:0] m_tdata    // coord_x, coord_y, coord_z, vertex_number
);

    logic [gvbm_pkg::IDX_W-1:0] divisions_reg;
    logic                       en;
    logic                       valid_reg [gvbm_pkg::ST_CLAMP:gvbm_pkg::ST_LAST];

    logic [gvbm_pkg::IDX_W-1:0]       idx_reg  [3];
    logic [gvbm_pkg::DIV_NUM_W-1:0]   num1_reg [3];
    logic                             neg_reg  [3];
    logic [gvbm_pkg::STRIDE_SQ_W-1:0] stride_sq_reg;
    logic [gvbm_pkg::PART_W-1:0]      part_reg;
    logic [gvbm_pkg::IDX_W-1:0]       iz_reg;
    gvbm_pkg::side_t                  side_reg [gvbm_pkg::ST_VN:gvbm_pkg::ST_LAST];

    logic [gvbm_pkg::MAG_W-1:0]     q1       [3];
    logic [gvbm_pkg::MAG_W-1:0]     mag_reg  [3];
    logic [gvbm_pkg::SQ_W-1:0]      sq_reg   [3];
    logic [gvbm_pkg::MAG_W-1:0]     m_reg;
    logic [gvbm_pkg::SUM_W-1:0]     sum_reg;
    logic [gvbm_pkg::ROOT_W-1:0]    root;
    logic [gvbm_pkg::DIV_NUM_W-1:0] num2_reg [3];
    logic [gvbm_pkg::DIV_DEN_W-1:0] den2_reg;
    logic [gvbm_pkg::MAG_W-1:0]     q2       [3];
    logic [gvbm_pkg::COORD_W-1:0]   coord    [3];

    logic                            last_valid;
    logic [gvbm_pkg::OUT_TDATA_W-1:0] last_data;
    logic                            out_valid_reg;
    logic [gvbm_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            skid_valid_reg;
    logic [gvbm_pkg::OUT_TDATA_W-1:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // configuration, zero treated as one division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisions_reg <= gvbm_pkg::IDX_W'(1);
        end else if (cfg_we) begin
            if (cfg_wdata == '0) begin
                divisions_reg <= gvbm_pkg::IDX_W'(1);
            end else if (cfg_wdata > gvbm_pkg::MAX_DIVISIONS) begin
                divisions_reg <= gvbm_pkg::MAX_DIVISIONS;
            end else begin
                divisions_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = gvbm_pkg::ST_CLAMP; s <= gvbm_pkg::ST_LAST; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[gvbm_pkg::ST_CLAMP] <= s_tvalid;
            for (int s = gvbm_pkg::ST_CLAMP + 1; s <= gvbm_pkg::ST_LAST; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // per-axis front end and dividers
    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [gvbm_pkg::IDX_W-1:0]     in_idx;
        logic [gvbm_pkg::STRIDE_W-1:0]  twice;
        logic [gvbm_pkg::STRIDE_W-1:0]  n_ext;
        logic                           neg;
        logic [gvbm_pkg::STRIDE_W-1:0]  diff;
        logic [2*gvbm_pkg::MAG_W-1:0]   sq_full;
        logic [2*gvbm_pkg::MAG_W-1:0]   prod_full;
        logic [gvbm_pkg::PROD_W-1:0]    prod_reg [gvbm_pkg::ST_SUM:gvbm_pkg::ST_ROUND];

        assign in_idx = s_tdata[k*gvbm_pkg::IDX_W +: gvbm_pkg::IDX_W];
        assign twice  = {idx_reg[k], 1'b0};
        assign n_ext  = gvbm_pkg::STRIDE_W'(divisions_reg);
        assign neg    = twice < n_ext;
        assign diff   = neg ? n_ext - twice : twice - n_ext;

        always_ff @(posedge aclk) begin
            if (en) begin
                idx_reg[k]  <= (in_idx > divisions_reg) ? divisions_reg : in_idx;
                neg_reg[k]  <= neg;
                num1_reg[k] <= (gvbm_pkg::DIV_NUM_W'(diff) << (gvbm_pkg::FRAC_BITS + 1))
                             + gvbm_pkg::DIV_NUM_W'(divisions_reg);
            end
        end

        gvbm_div u_div_cube (
            .aclk     (aclk),
            .en       (en),
            .dividend (num1_reg[k]),
            .divisor  (gvbm_pkg::DIV_DEN_W'(divisions_reg) << 1),
            .quotient (q1[k])
        );

        assign sq_full   = q1[k] * q1[k];
        assign prod_full = mag_reg[k] * m_reg;

        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[k]                 <= q1[k];
                sq_reg[k]                  <= sq_full[gvbm_pkg::SQ_W-1:0];
                prod_reg[gvbm_pkg::ST_SUM] <= prod_full[gvbm_pkg::PROD_W-1:0];
                for (int s = gvbm_pkg::ST_SUM + 1; s <= gvbm_pkg::ST_ROUND; s++) begin
                    prod_reg[s] <= prod_reg[s-1];
                end
                num2_reg[k] <= (gvbm_pkg::DIV_NUM_W'(prod_reg[gvbm_pkg::ST_ROUND]) << 1)
                             + gvbm_pkg::DIV_NUM_W'(root);
            end
        end

        gvbm_div u_div_ball (
            .aclk     (aclk),
            .en       (en),
            .dividend (num2_reg[k]),
            .divisor  (den2_reg),
            .quotient (q2[k])
        );

        assign coord[k] = side_reg[gvbm_pkg::ST_LAST].neg[k]
                        ? gvbm_pkg::COORD_W'(0) - gvbm_pkg::COORD_W'(q2[k])
                        : gvbm_pkg::COORD_W'(q2[k]);
    end

    // vertex number and shared stages
    logic [gvbm_pkg::STRIDE_W-1:0]    stride;
    logic [2*gvbm_pkg::STRIDE_W-1:0]  stride_sq;
    logic [2*gvbm_pkg::STRIDE_W-1:0]  part_full;
    logic [gvbm_pkg::MAG_W-1:0]       max_xy;
    logic [gvbm_pkg::MAG_W-1:0]       max_xyz;

    assign stride    = gvbm_pkg::STRIDE_W'(divisions_reg) + gvbm_pkg::STRIDE_W'(1);
    assign stride_sq = stride * stride;
    assign part_full = (2*gvbm_pkg::STRIDE_W)'(idx_reg[1])
                     * (2*gvbm_pkg::STRIDE_W)'(stride)
                     + (2*gvbm_pkg::STRIDE_W)'(idx_reg[0]);
    assign max_xy    = (q1[1] > q1[0]) ? q1[1] : q1[0];
    assign max_xyz   = (q1[2] > max_xy) ? q1[2] : max_xy;

    always_ff @(posedge aclk) begin
        if (en) begin
            stride_sq_reg <= stride_sq[gvbm_pkg::STRIDE_SQ_W-1:0];
            part_reg      <= part_full[gvbm_pkg::PART_W-1:0];
            iz_reg        <= idx_reg[2];
            side_reg[gvbm_pkg::ST_VN].vn  <= gvbm_pkg::VN_W'(iz_reg)
                                           * gvbm_pkg::VN_W'(stride_sq_reg)
                                           + gvbm_pkg::VN_W'(part_reg);
            side_reg[gvbm_pkg::ST_VN].neg <= {neg_reg[2], neg_reg[1], neg_reg[0]};
            for (int s = gvbm_pkg::ST_VN + 1; s <= gvbm_pkg::ST_LAST; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            m_reg    <= max_xyz;
            sum_reg  <= gvbm_pkg::SUM_W'(sq_reg[0]) + gvbm_pkg::SUM_W'(sq_reg[1])
                      + gvbm_pkg::SUM_W'(sq_reg[2]);
            den2_reg <= gvbm_pkg::DIV_DEN_W'(root) << 1;
        end
    end

    gvbm_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    // output register with skid stage
    assign last_valid = valid_reg[gvbm_pkg::ST_LAST] && en;
    assign last_data  = gvbm_pkg::OUT_TDATA_W'({side_reg[gvbm_pkg::ST_LAST].vn,
                                                coord[2], coord[1], coord[0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || last_valid;
            skid_valid_reg <= 1'b0;
        end else if (last_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : last_data;
        end else if (last_valid) begin
            skid_data_reg <= last_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ src/gvbm_chk.sv @@
// port-level checker for the grid vertex to ball mapper, with its bind
module gvbm_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gvbm_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input backpressure only while a result was waiting
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && $past(aresetn) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_coord_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            $signed(m_tdata[15:0])  <= gvbm_pkg::COORD_ONE &&
            $signed(m_tdata[15:0])  >= -gvbm_pkg::COORD_ONE &&
            $signed(m_tdata[31:16]) <= gvbm_pkg::COORD_ONE &&
            $signed(m_tdata[31:16]) >= -gvbm_pkg::COORD_ONE &&
            $signed(m_tdata[47:32]) <= gvbm_pkg::COORD_ONE &&
            $signed(m_tdata[47:32]) >= -gvbm_pkg::COORD_ONE &&
            m_tdata[79:78] == 2'b00)
        else $error("coordinate outside unit range");

endmodule

bind grid_vertex_to_ball_map gvbm_chk u_gvbm_chk (.*);
